// ===== rtl/audio_activity_segmenter_defines.svh =====
// Assertion macros shared by the audio activity segmenter RTL.
`ifndef AUDIO_ACTIVITY_SEGMENTER_DEFINES_SVH
`define AUDIO_ACTIVITY_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("aas assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("aas assertion failed");

`endif

// ===== rtl/aas_pkg.sv =====
// Types and constants of the audio activity segmenter.
package aas_pkg;

  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned ThrW         = 15;
  localparam int unsigned GapW         = 24;
  localparam int unsigned IdxOutW      = 32;
  localparam int unsigned PaddrW       = 3;
  localparam int unsigned PdataW       = 32;
  localparam int unsigned ResDepth     = 4;
  localparam int unsigned ResPtrW      = 2;
  localparam int unsigned ResCntW      = 3;

  localparam logic [ThrW-1:0] ThresholdReset = ThrW'(500);
  localparam logic [GapW-1:0] GapReset       = GapW'(22050);

  // Register indexes, decoded from paddr[2].
  localparam logic RegThreshold = 1'b0;
  localparam logic RegGap       = 1'b1;

  localparam logic KindSegment = 1'b0;
  localparam logic KindOverall = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               end_marker;
  } in_t;

  typedef struct packed {
    logic                record_kind;
    logic [IdxOutW-1:0] start_index;
    logic [IdxOutW-1:0] end_index;
    logic                last_of_run;
  } out_t;

  // Results that one accepted request adds to the result queue.
  typedef struct packed {
    logic [1:0] num;
    out_t       first;
    out_t       second;
  } push_t;

endpackage

// ===== rtl/audio_activity_segmenter.sv =====
// Top level of the audio activity segmenter.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   in_data_i (aas_pkg::in_t)
//   out       output     out_valid_o/out_ready_i out_data_o (aas_pkg::out_t)
//   config    input      psel/penable/pwrite     paddr, pwdata, prdata
//
// One request is accepted per cycle while in_ready_o is high; its results reach the
// four-entry result queue at the same edge; an empty queue shows them the next cycle.
// The output drains one result per cycle while out_ready_i is high.
// in_ready_o is high while the queue has at least two free entries.
// Reset clears all segment state and sets the registers to their defaults.
`include "audio_activity_segmenter_defines.svh"

module audio_activity_segmenter #(
  parameter int unsigned COUNT_BITS = aas_pkg::CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  aas_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output aas_pkg::out_t              out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aas_pkg::PaddrW-1:0] paddr,
  input  logic [aas_pkg::PdataW-1:0] pwdata,
  output logic [aas_pkg::PdataW-1:0] prdata,
  output logic                       pready
);

  logic [aas_pkg::ThrW-1:0]    threshold;
  logic [aas_pkg::GapW-1:0]    gap;
  aas_pkg::push_t              push;
  logic                        accept;
  logic                        pop;
  logic                        empty;
  logic                        seg_open;
  logic [aas_pkg::ResCntW-1:0] res_count;

  assign in_ready_o  = (res_count <= aas_pkg::ResCntW'(aas_pkg::ResDepth - 2));
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = !empty;
  assign pop         = out_valid_o & out_ready_i;

  aas_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold),
    .gap_o       (gap)
  );

  aas_detect #(
    .COUNT_BITS (COUNT_BITS)
  ) u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .threshold_i (threshold),
    .gap_i       (gap),
    .push_o      (push),
    .seg_open_o  (seg_open)
  );

  aas_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (out_data_o),
    .empty_o (empty),
    .count_o (res_count)
  );

  // The queue never holds more than its depth.
  `AAS_ASSERT_NOW(a_fifo_bound, clk_i, rst_ni, 1'b1, res_count <= aas_pkg::ResCntW'(aas_pkg::ResDepth))
  // An end request with an open segment leaves results to deliver.
  `AAS_ASSERT_NEXT(a_flush_out, clk_i, rst_ni, accept && in_data_i.end_marker && seg_open, out_valid_o)
  // An end request always closes the segment.
  `AAS_ASSERT_NEXT(a_flush_close, clk_i, rst_ni, accept && in_data_i.end_marker, !seg_open)

endmodule

// ===== rtl/aas_cfg.sv =====
// APB-style configuration registers of the audio activity segmenter.
module aas_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aas_pkg::PaddrW-1:0]       paddr,
  input  logic [aas_pkg::PdataW-1:0]       pwdata,
  output logic [aas_pkg::PdataW-1:0]       prdata,
  output logic                             pready,
  output logic [aas_pkg::ThrW-1:0]         threshold_o,
  output logic [aas_pkg::GapW-1:0]         gap_o
);

  logic [aas_pkg::ThrW-1:0] thr_q;
  logic [aas_pkg::GapW-1:0] gap_q;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= aas_pkg::ThresholdReset;
      gap_q <= aas_pkg::GapReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        aas_pkg::RegThreshold: thr_q <= pwdata[aas_pkg::ThrW-1:0];
        aas_pkg::RegGap:       gap_q <= pwdata[aas_pkg::GapW-1:0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      aas_pkg::RegThreshold: prdata = aas_pkg::PdataW'(thr_q);
      aas_pkg::RegGap:       prdata = aas_pkg::PdataW'(gap_q);
      default:               prdata = '0;
    endcase
  end

  assign threshold_o = thr_q;
  assign gap_o       = gap_q;

endmodule

// ===== rtl/aas_detect.sv =====
// Per-sample activity test, segment tracking and result generation.
module aas_detect #(
  parameter int unsigned COUNT_BITS = aas_pkg::CountBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  aas_pkg::in_t             in_data_i,
  input  logic [aas_pkg::ThrW-1:0] threshold_i,
  input  logic [aas_pkg::GapW-1:0] gap_i,
  output aas_pkg::push_t           push_o,
  output logic                     seg_open_o
);

  localparam int unsigned CmpW = (COUNT_BITS > aas_pkg::GapW) ? COUNT_BITS : aas_pkg::GapW;
  localparam int unsigned IdxW = (COUNT_BITS > aas_pkg::IdxOutW) ? COUNT_BITS
                                                                  : aas_pkg::IdxOutW;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] begin_q, begin_d;
  logic [COUNT_BITS-1:0] latest_q, latest_d;
  logic [COUNT_BITS-1:0] first_q, first_d;
  logic                  open_q, open_d;

  logic [16:0]     mag;
  logic            active;
  logic [CmpW-1:0] gap_diff;
  logic            gap_over;

  // Indices leave in their low 32 bits; a narrow counter is zero-extended.
  function automatic logic [aas_pkg::IdxOutW-1:0] to_idx(logic [COUNT_BITS-1:0] v);
    logic [IdxW-1:0] w;
    w = IdxW'(v);
    return w[aas_pkg::IdxOutW-1:0];
  endfunction

  // The most negative sample has magnitude 32768, so the magnitude needs 17 bits.
  assign mag = in_data_i.sample_value[15] ? ({1'b0, ~in_data_i.sample_value} + 17'd1)
                                          : {1'b0, in_data_i.sample_value};
  assign active   = mag > {2'b00, threshold_i};
  assign gap_diff = CmpW'(count_q) - CmpW'(latest_q);
  assign gap_over = gap_diff > CmpW'(gap_i);

  always_comb begin
    count_d  = count_q;
    begin_d  = begin_q;
    latest_d = latest_q;
    first_d  = first_q;
    open_d   = open_q;

    push_o                    = '0;
    push_o.first.record_kind  = aas_pkg::KindSegment;
    push_o.first.start_index  = to_idx(begin_q);
    push_o.first.end_index    = to_idx(latest_q);
    push_o.first.last_of_run  = 1'b1;
    push_o.second.record_kind = aas_pkg::KindOverall;
    push_o.second.start_index = to_idx(first_q);
    push_o.second.end_index   = to_idx(latest_q);
    push_o.second.last_of_run = 1'b1;

    if (accept_i) begin
      if (in_data_i.end_marker) begin
        if (open_q) begin
          push_o.num               = 2'd2;
          push_o.first.last_of_run = 1'b0;
        end
        count_d  = '0;
        begin_d  = '0;
        latest_d = '0;
        first_d  = '0;
        open_d   = 1'b0;
      end else begin
        if (active) begin
          if (!open_q) begin
            open_d  = 1'b1;
            begin_d = count_q;
            first_d = count_q;
          end else if (gap_over) begin
            push_o.num = 2'd1;
            begin_d    = count_q;
          end
          latest_d = count_q;
        end
        // The counter saturates at all ones.
        if (!(&count_q)) begin
          count_d = count_q + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      begin_q  <= '0;
      latest_q <= '0;
      first_q  <= '0;
      open_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      begin_q  <= begin_d;
      latest_q <= latest_d;
      first_q  <= first_d;
      open_q   <= open_d;
    end
  end

  assign seg_open_o = open_q;

endmodule

// ===== rtl/aas_result_fifo.sv =====
// Result queue that takes up to two results per cycle and gives one.
module aas_result_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  aas_pkg::push_t               push_i,
  input  logic                         pop_i,
  output aas_pkg::out_t                head_o,
  output logic                         empty_o,
  output logic [aas_pkg::ResCntW-1:0] count_o
);

  aas_pkg::out_t                 mem_q [aas_pkg::ResDepth];
  logic [aas_pkg::ResPtrW-1:0]   wr_q, wr_d;
  logic [aas_pkg::ResPtrW-1:0]   rd_q, rd_d;
  logic [aas_pkg::ResCntW-1:0]   cnt_q, cnt_d;
  logic [aas_pkg::ResPtrW-1:0]   wr_next;

  assign wr_next = wr_q + aas_pkg::ResPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_comb begin
    wr_d  = wr_q + aas_pkg::ResPtrW'(push_i.num);
    rd_d  = rd_q + aas_pkg::ResPtrW'(pop_i);
    cnt_d = cnt_q + aas_pkg::ResCntW'(push_i.num) - aas_pkg::ResCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the audio activity segmenter: directed table, then random phases.
module tb;
  import aas_pkg::*;

  localparam int unsigned CntW       = CountBitsDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 190;

  typedef enum logic [1:0] {RowSample, RowEnd, RowThreshold, RowGap} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    int          value;
    bit          typed;
    int unsigned n;
    out_t        r0;
    out_t        r1;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  // Predictor copy of the block's registers and segment state.
  logic [ThrW-1:0]     cur_threshold;
  logic [GapW-1:0]     cur_gap;
  logic [CntW-1:0]     next_index;
  logic                seg_active;
  logic [CntW-1:0]     seg_first;
  logic [CntW-1:0]     last_hit;
  logic [CntW-1:0]     span_first;

  out_t                expected_records[$];
  stim_row_t           directed_rows[$];
  int unsigned         error_count;
  int unsigned         cycle_count;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;

  audio_activity_segmenter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    error_count++;
    $display("mismatch: %s got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // Advances the segment state by one request and returns the records it yields.
  function automatic int unsigned track_request(input in_t req, output out_t rec0,
                                                output out_t rec1);
    int               magnitude;
    logic [CntW-1:0]  idx;
    int unsigned      produced;
    idx      = next_index;
    produced = 0;
    rec0     = '0;
    rec1     = '0;
    if (req.end_marker) begin
      if (seg_active) begin
        rec0 = '{KindSegment, IdxOutW'(seg_first), IdxOutW'(last_hit), 1'b0};
        rec1 = '{KindOverall, IdxOutW'(span_first), IdxOutW'(last_hit), 1'b1};
        produced = 2;
      end
      next_index = '0;
      seg_active = 1'b0;
      seg_first  = '0;
      last_hit   = '0;
      span_first = '0;
      return produced;
    end
    magnitude = (req.sample_value < 0) ? -int'(req.sample_value) : int'(req.sample_value);
    if (magnitude > int'(cur_threshold)) begin
      if (!seg_active) begin
        seg_active = 1'b1;
        seg_first  = idx;
        span_first = idx;
      end else if ((idx - last_hit) > CntW'(cur_gap)) begin
        rec0 = '{KindSegment, IdxOutW'(seg_first), IdxOutW'(last_hit), 1'b1};
        produced = 1;
        seg_first = idx;
      end
      last_hit = idx;
    end
    if (next_index != '1) next_index = next_index + 1'b1;
    return produced;
  endfunction

  task automatic send_request(input in_t req, input bit typed, input int unsigned typed_n,
                              input out_t t0, input out_t t1);
    int unsigned idles;
    int unsigned n;
    out_t        p0;
    out_t        p1;
    idles = 0;
    while (idles < 40 && $urandom_range(99) < send_idle_pct) idles++;
    @(negedge clk_i);
    if (idles > 0) begin
      in_valid_i <= 1'b0;
      repeat (idles) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    n = track_request(req, p0, p1);
    if (typed) n = typed_n;
    if (typed) begin
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) expected_records.push_back(p0);
    if (n > 1) expected_records.push_back(p1);
  endtask

  // Stops requests and waits until every expected record has come out.
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic reg_index, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_index == RegThreshold) cur_threshold = value[ThrW-1:0];
    else cur_gap = value[GapW-1:0];
    want = (reg_index == RegThreshold) ? 32'(cur_threshold) : 32'(cur_gap);
    // Read the register back to confirm the write landed.
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) flag_mismatch("register readback", prdata, want);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input row_kind_e kind, input int value, input bit typed,
                         input int unsigned n, input out_t r0, input out_t r1);
    stim_row_t row;
    row = '{kind, value, typed, n, r0, r1};
    directed_rows.push_back(row);
  endtask

  // Receiver side: randomly withholds ready.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    out_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_records.size() == 0) begin
        flag_mismatch("unexpected record, start_index", out_data_o.start_index, '0);
      end else begin
        want = expected_records.pop_front();
        if (out_data_o.record_kind !== want.record_kind)
          flag_mismatch("record_kind", out_data_o.record_kind, want.record_kind);
        if (out_data_o.start_index !== want.start_index)
          flag_mismatch("start_index", out_data_o.start_index, want.start_index);
        if (out_data_o.end_index !== want.end_index)
          flag_mismatch("end_index", out_data_o.end_index, want.end_index);
        if (out_data_o.last_of_run !== want.last_of_run)
          flag_mismatch("last_of_run", out_data_o.last_of_run, want.last_of_run);
      end
    end
  end

  initial begin
    in_t         req;
    stim_row_t   row;
    out_t        none;
    logic [ThrW-1:0] thr_set [6];
    logic [GapW-1:0] gap_set [6];
    int unsigned roll;
    int          mag;
    bit          burst;

    none          = '0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 18;
    recv_idle_pct = 86;
    cur_threshold = ThresholdReset;
    cur_gap       = GapReset;
    next_index    = '0;
    seg_active    = 1'b0;
    seg_first     = '0;
    last_hit      = '0;
    span_first    = '0;
    burst         = 1'b0;

    thr_set = '{ThrW'(0), ThrW'(32767), ThrW'(500), ThrW'(1000), ThrW'(12345), ThrW'(200)};
    gap_set = '{GapW'(0), GapW'(3), GapW'(16777215), GapW'(4), GapW'(1), GapW'(10)};

    // An end with nothing active yields nothing; the threshold compare is strict.
    add_row(RowEnd, 16'h7fff, 1, 0, none, none);
    add_row(RowSample, 0, 0, 0, none, none);
    add_row(RowSample, 500, 0, 0, none, none);
    add_row(RowSample, 501, 0, 0, none, none);
    add_row(RowSample, -500, 0, 0, none, none);
    add_row(RowSample, -501, 0, 0, none, none);
    add_row(RowSample, 32767, 0, 0, none, none);
    add_row(RowSample, -32768, 0, 0, none, none);
    add_row(RowEnd, -1, 1, 2, '{KindSegment, 32'd2, 32'd6, 1'b0},
            '{KindOverall, 32'd2, 32'd6, 1'b1});
    add_row(RowSample, -32768, 0, 0, none, none);
    add_row(RowEnd, 0, 1, 2, '{KindSegment, 32'd0, 32'd0, 1'b0},
            '{KindOverall, 32'd0, 32'd0, 1'b1});
    // With no gap allowed, every active sample after the first starts a new segment.
    add_row(RowGap, 0, 0, 0, none, none);
    add_row(RowSample, 1000, 0, 0, none, none);
    add_row(RowSample, 1000, 0, 0, none, none);
    add_row(RowSample, 0, 0, 0, none, none);
    add_row(RowSample, -1000, 0, 0, none, none);
    add_row(RowEnd, 12345, 0, 0, none, none);
    add_row(RowThreshold, 0, 0, 0, none, none);
    add_row(RowSample, 1, 0, 0, none, none);
    add_row(RowSample, 0, 0, 0, none, none);
    add_row(RowGap, 16777215, 0, 0, none, none);
    add_row(RowSample, -1, 0, 0, none, none);
    // Only the most negative sample clears the largest threshold.
    add_row(RowThreshold, 32767, 0, 0, none, none);
    add_row(RowSample, 32767, 0, 0, none, none);
    add_row(RowSample, -32768, 0, 0, none, none);
    add_row(RowEnd, 0, 1, 2, '{KindSegment, 32'd0, 32'd4, 1'b0},
            '{KindOverall, 32'd0, 32'd4, 1'b1});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values, read back through the register port.
    @(negedge clk_i);
    psel    <= 1'b1;
    paddr   <= {RegThreshold, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(ThresholdReset)) flag_mismatch("threshold reset", prdata, ThresholdReset);
    @(negedge clk_i);
    penable <= 1'b0;
    paddr   <= {RegGap, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(GapReset)) flag_mismatch("gap reset", prdata, GapReset);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      case (row.kind)
        RowThreshold: begin
          wait_for_drain();
          write_register(RegThreshold, 32'(row.value));
        end
        RowGap: begin
          wait_for_drain();
          write_register(RegGap, 32'(row.value));
        end
        default: begin
          req.sample_value = 16'(row.value);
          req.end_marker   = (row.kind == RowEnd);
          send_request(req, row.typed, row.n, row.r0, row.r1);
        end
      endcase
    end

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 86 : 0;
      recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 18 : 0;
      wait_for_drain();
      write_register(RegThreshold, 32'(thr_set[ph]));
      write_register(RegGap, 32'(gap_set[ph]));
      for (int i = 0; i < PhaseItems; i++) begin
        // Hold the sender off until the block has emptied once per phase.
        if (i == 60) wait_for_drain();
        if ($urandom_range(99) < 12) burst = ~burst;
        roll = $urandom_range(99);
        req.end_marker = 1'b0;
        if (roll < 3) begin
          req.end_marker   = 1'b1;
          req.sample_value = 16'($urandom);
        end else if (roll < 20) begin
          req.sample_value = 16'($urandom);
        end else if ($urandom_range(99) < (burst ? 80 : 5)) begin
          mag = $urandom_range(32768, int'(cur_threshold) + 1);
          if (mag == 32768 || $urandom_range(1)) req.sample_value = 16'(-mag);
          else req.sample_value = 16'(mag);
        end else begin
          mag = $urandom_range(int'(cur_threshold), 0);
          req.sample_value = $urandom_range(1) ? 16'(-mag) : 16'(mag);
        end
        send_request(req, 0, 0, none, none);
      end
    end

    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
